### rtl/core/hcs_pkg.sv
// shared constants, types and control structs of the histogram contrast stretch unit
`timescale 1ns / 1ps

package hcs_pkg;

  // pixel and gray widths
  localparam int unsigned ChanW     = 8;
  localparam int unsigned LumaW     = 16;
  localparam int unsigned LumaShift = 8;
  localparam int unsigned GrayMax   = 255;

  // luma weights
  localparam int unsigned LumaR = 76;
  localparam int unsigned LumaG = 150;
  localparam int unsigned LumaB = 30;

  // histogram geometry
  localparam int unsigned Bins     = 256;
  localparam int unsigned BinAddrW = 8;

  // clip threshold is pixel count over 64
  localparam int unsigned ClipShift = 6;

  // default frame size limit
  localparam int unsigned MaxPixelsDef = 4194304;

  // pass codes carried by func
  localparam logic FuncHist    = 1'b0;
  localparam logic FuncStretch = 1'b1;

  typedef logic [ChanW-1:0]    chan_t;
  typedef logic [BinAddrW-1:0] bin_addr_t;

  // histogram memory control
  typedef struct packed {
    logic      wr_en;
    logic      clr;
    bin_addr_t wr_addr;
    bin_addr_t rd_a_addr;
    bin_addr_t rd_b_addr;
  } hist_ctrl_t;

endpackage

### rtl/core/hcs_if.sv
// valid/ready channel interfaces for pixel input and stretched result
`timescale 1ns / 1ps

interface hcs_in_if;
  logic          valid;
  logic          ready;
  logic          func;
  hcs_pkg::chan_t red;
  hcs_pkg::chan_t green;
  hcs_pkg::chan_t blue;
  logic          last_of_pass;

  modport source (output valid, func, red, green, blue, last_of_pass, input ready);
  modport sink   (input valid, func, red, green, blue, last_of_pass, output ready);
endinterface

interface hcs_out_if;
  logic          valid;
  logic          ready;
  hcs_pkg::chan_t stretched_gray;
  hcs_pkg::chan_t low_level_out;
  hcs_pkg::chan_t high_level_out;

  modport source (output valid, stretched_gray, low_level_out, high_level_out, input ready);
  modport sink   (input valid, stretched_gray, low_level_out, high_level_out, output ready);
endinterface

### rtl/core/hcs_gray.sv
// registered rgb to gray conversion
`timescale 1ns / 1ps

module hcs_gray (
  input  logic           clk_i,
  input  logic           en_i,
  input  hcs_pkg::chan_t red_i,
  input  hcs_pkg::chan_t green_i,
  input  hcs_pkg::chan_t blue_i,
  output hcs_pkg::chan_t gray_o
);
  import hcs_pkg::*;

  logic [LumaW-1:0] sum;
  chan_t            gray_q;

  // weighted sum, top byte is the gray value
  always_comb begin
    sum = LumaW'(red_i)   * LumaW'(LumaR)
        + LumaW'(green_i) * LumaW'(LumaG)
        + LumaW'(blue_i)  * LumaW'(LumaB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gray_q <= sum[LumaShift +: ChanW];
    end
  end

  assign gray_o = gray_q;

endmodule

### rtl/core/hcs_hist_mem.sv
// histogram bin memory, two registered read ports, one write port, per-bin valid flags
`timescale 1ns / 1ps

module hcs_hist_mem #(
  parameter int unsigned CntW = 23
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcs_pkg::hist_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     wr_data_i,
  output logic [CntW-1:0]     rd_a_data_o,
  output logic [CntW-1:0]     rd_b_data_o
);
  import hcs_pkg::*;

  logic [CntW-1:0] mem [Bins];
  logic [Bins-1:0] vld_q;
  logic [CntW-1:0] rd_a_q;
  logic [CntW-1:0] rd_b_q;
  logic            rd_a_vld_q;
  logic            rd_b_vld_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    rd_a_q <= mem[ctrl_i.rd_a_addr];
    rd_b_q <= mem[ctrl_i.rd_b_addr];
  end

  // bin valid flags, an unwritten bin reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.wr_en) begin
        vld_q[ctrl_i.wr_addr] <= 1'b1;
      end
      rd_a_vld_q <= vld_q[ctrl_i.rd_a_addr];
      rd_b_vld_q <= vld_q[ctrl_i.rd_b_addr];
    end
  end

  assign rd_a_data_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_b_data_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

### rtl/core/hcs_div.sv
// restoring divider, 16-bit numerator by 8-bit divisor, one quotient bit per cycle
`timescale 1ns / 1ps

module hcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [2*hcs_pkg::ChanW-1:0] num_i,
  input  hcs_pkg::chan_t              den_i,
  output logic                        done_o,
  output hcs_pkg::chan_t              quo_o
);
  import hcs_pkg::*;

  localparam int unsigned StepW = $clog2(ChanW);

  chan_t            rem_q;
  chan_t            num_lo_q;
  chan_t            den_q;
  chan_t            quo_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [ChanW:0]   trial;
  logic             fits;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem_q, num_lo_q[ChanW-1]};
    fits  = trial >= {1'b0, den_q};
  end

  // the quotient fits 8 bits because the numerator is below 256 times the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
      rem_q    <= '0;
      num_lo_q <= '0;
      den_q    <= '0;
      quo_q    <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      done_q   <= 1'b0;
      step_q   <= '0;
      rem_q    <= num_i[2*ChanW-1:ChanW];
      num_lo_q <= num_i[ChanW-1:0];
      den_q    <= den_i;
    end else if (busy_q) begin
      rem_q    <= fits ? ChanW'(trial - {1'b0, den_q}) : trial[ChanW-1:0];
      num_lo_q <= {num_lo_q[ChanW-2:0], 1'b0};
      quo_q    <= {quo_q[ChanW-2:0], fits};
      step_q   <= step_q + StepW'(1);
      if (step_q == StepW'(ChanW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/histogram_contrast_stretch_unit.sv
// Histogram pass beat: gray conversion, bin read and bin write run in order before the next ready.
// The last beat of a histogram pass then scans both ends of the histogram together over 256
// bins through the two memory read ports.
// Stretch pass beat: clamped values skip the 8-step divider, others wait for it; the result
// sits in an output register, so the next beat is taken while it waits.
// Reset (async, active low) clears bin valid flags, pixel count, clip levels 0 and 255.
`timescale 1ns / 1ps

module histogram_contrast_stretch_unit #(
  parameter int unsigned MaxPixels = hcs_pkg::MaxPixelsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  hcs_in_if.sink    in_i,
  hcs_out_if.source out_o
);
  import hcs_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPixels + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAY,
    S_HREAD,
    S_SCAN,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  logic              func_q;
  logic              last_q;
  chan_t             gray;
  chan_t             low_q;
  chan_t             high_q;
  logic [CntW-1:0]   cnt_q;
  chan_t             res_q;
  logic [BinAddrW:0] scan_idx_q;
  logic              scan_vld_q;
  bin_addr_t         scan_pos_q;
  logic [CntW-1:0]   run_lo_q;
  logic [CntW-1:0]   run_hi_q;
  logic              found_lo_q;
  logic              found_hi_q;
  logic              out_valid_q;
  chan_t             out_gray_q;
  chan_t             out_low_q;
  chan_t             out_high_q;

  hist_ctrl_t        hist_ctrl;
  logic [CntW-1:0]   rd_a_data;
  logic [CntW-1:0]   rd_b_data;
  logic [CntW-1:0]   thr;
  logic [CntW-1:0]   run_lo_nx;
  logic [CntW-1:0]   run_hi_nx;
  logic              in_acc;
  logic              out_acc;
  logic              out_free;
  logic              below;
  logic              above;
  logic              div_start;
  logic              div_done;
  chan_t             div_quo;
  chan_t             diff;
  logic [2*ChanW-1:0] num;
  logic              room;

  // handshakes
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // gray conversion
  hcs_gray u_gray (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .red_i   (in_i.red),
    .green_i (in_i.green),
    .blue_i  (in_i.blue),
    .gray_o  (gray)
  );

  // histogram memory control
  always_comb begin
    hist_ctrl.rd_a_addr = (state_q == S_SCAN) ? scan_idx_q[BinAddrW-1:0] : gray;
    hist_ctrl.rd_b_addr = ~scan_idx_q[BinAddrW-1:0];
    hist_ctrl.wr_en     = (state_q == S_HREAD);
    hist_ctrl.wr_addr   = gray;
    hist_ctrl.clr       = (state_q == S_OUT) && out_free && last_q;
  end

  hcs_hist_mem #(
    .CntW (CntW)
  ) u_hist_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (hist_ctrl),
    .wr_data_i   (rd_a_data + CntW'(1)),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  // scan accumulation from both ends
  assign thr       = cnt_q >> ClipShift;
  assign run_lo_nx = run_lo_q + rd_a_data;
  assign run_hi_nx = run_hi_q + rd_b_data;
  assign room      = cnt_q < CntW'(MaxPixels);

  // stretch classification and divider operands
  assign below     = gray < low_q;
  assign above     = gray > high_q;
  assign diff      = gray - low_q;
  assign num       = {diff, {ChanW{1'b0}}} - {{ChanW{1'b0}}, diff};
  assign div_start = (state_q == S_GRAY) && (func_q == FuncStretch) && !below && !above
                   && (high_q != low_q);

  hcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (high_q - low_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // control sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FuncHist;
      last_q      <= 1'b0;
      low_q       <= '0;
      high_q      <= ChanW'(GrayMax);
      cnt_q       <= '0;
      res_q       <= '0;
      scan_idx_q  <= '0;
      scan_vld_q  <= 1'b0;
      scan_pos_q  <= '0;
      run_lo_q    <= '0;
      run_hi_q    <= '0;
      found_lo_q  <= 1'b0;
      found_hi_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_gray_q  <= '0;
      out_low_q   <= '0;
      out_high_q  <= '0;
    end else begin
      // drop the result beat once taken, unless a new one loads in the same cycle
      if (out_acc && !((state_q == S_OUT) && out_free)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            func_q  <= in_i.func;
            last_q  <= in_i.last_of_pass;
            state_q <= S_GRAY;
          end
        end
        S_GRAY: begin
          if (func_q == FuncHist) begin
            if (room) begin
              state_q <= S_HREAD;
            end else if (last_q) begin
              scan_idx_q <= '0;
              scan_vld_q <= 1'b0;
              run_lo_q   <= '0;
              run_hi_q   <= '0;
              found_lo_q <= 1'b0;
              found_hi_q <= 1'b0;
              low_q      <= '0;
              high_q     <= ChanW'(GrayMax);
              state_q    <= S_SCAN;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (below) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else if (above) begin
            res_q   <= ChanW'(GrayMax);
            state_q <= S_OUT;
          end else if (high_q == low_q) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_HREAD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last_q) begin
            scan_idx_q <= '0;
            scan_vld_q <= 1'b0;
            run_lo_q   <= '0;
            run_hi_q   <= '0;
            found_lo_q <= 1'b0;
            found_hi_q <= 1'b0;
            low_q      <= '0;
            high_q     <= ChanW'(GrayMax);
            state_q    <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          scan_vld_q <= !scan_idx_q[BinAddrW];
          scan_pos_q <= scan_idx_q[BinAddrW-1:0];
          if (!scan_idx_q[BinAddrW]) begin
            scan_idx_q <= scan_idx_q + (BinAddrW + 1)'(1);
          end
          if (scan_vld_q) begin
            run_lo_q <= run_lo_nx;
            run_hi_q <= run_hi_nx;
            if (!found_lo_q && (run_lo_nx > thr)) begin
              found_lo_q <= 1'b1;
              low_q      <= scan_pos_q;
            end
            if (!found_hi_q && (run_hi_nx > thr)) begin
              found_hi_q <= 1'b1;
              high_q     <= ~scan_pos_q;
            end
          end
          if (scan_idx_q[BinAddrW] && !scan_vld_q) begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= div_quo;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_gray_q  <= res_q;
            out_low_q   <= low_q;
            out_high_q  <= high_q;
            if (last_q) begin
              cnt_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_o.valid          = out_valid_q;
  assign out_o.stretched_gray = out_gray_q;
  assign out_o.low_level_out  = out_low_q;
  assign out_o.high_level_out = out_high_q;

  // clip levels never cross
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_low_q <= out_high_q))
    else $error("dark clip level above bright clip level");

  // pixel count saturates at the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPixels))
    else $error("pixel count beyond frame limit");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result with no division pending");

  // histogram writes and clears never overlap a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (!hist_ctrl.wr_en && !hist_ctrl.clr))
    else $error("histogram modified during scan");

endmodule
